>>> hw/rtl/rsp_pkg.sv
// shared widths and entry type for the population ranking block
`default_nettype none

package rsp_pkg;

    localparam int FIT_W  = 32;
    localparam int TAG_W  = 8;
    localparam int SLOT_W = 5;
    localparam int RANK_W = 5;
    localparam int SUM_W  = 40;
    localparam int ENT_W  = FIT_W + TAG_W;

    // one stored population entry as it sits in the ram word
    typedef struct packed {
        logic [FIT_W-1:0] fit;
        logic [TAG_W-1:0] tag;
    } t_entry;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SORT = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/rank_sort_population_by_fitness.sv
// population store with descending selection sort, ranked readout and mean
//
// input: an item is taken when start is high and busy is low. action 0 loads
// fitness and tag into one slot in that cycle (slots at or beyond POP_SIZE are
// dropped); loads can be issued every cycle and never raise busy.
// action 1 sorts the store high to low and reads it out: busy rises for the
// whole operation, and POP_SIZE results follow on consecutive cycles, each
// marked by o_valid for one cycle, rank 0 first. o_last and o_mean_fitness
// belong to the final result; the mean field reads zero on the others.
// a sort makes one pass for each slot i = 0 .. POP_SIZE-1; each pass streams
// the remaining entries through the one read port of the store ram and then
// makes the two swap writes. after the last pass come the mean divide and
// then the readout.
// results cannot be held off, so the receiver must take each one as it comes.
// reset clears control and the fitness sum; store contents are undefined
// until loaded, and every slot must be loaded before a sort.
`default_nettype none

module rank_sort_population_by_fitness #(
    parameter int POP_SIZE = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_action,
    input  wire logic [rsp_pkg::SLOT_W-1:0]        i_slot,
    input  wire logic signed [rsp_pkg::FIT_W-1:0]  i_fitness,
    input  wire logic [rsp_pkg::TAG_W-1:0]         i_tag,
    output logic                                   o_valid,
    output logic [rsp_pkg::RANK_W-1:0]             o_rank,
    output logic signed [rsp_pkg::FIT_W-1:0]       o_ranked_fitness,
    output logic [rsp_pkg::TAG_W-1:0]              o_ranked_tag,
    output logic signed [rsp_pkg::FIT_W-1:0]       o_mean_fitness,
    output logic                                   o_last
);
    import rsp_pkg::*;

    localparam int AW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(POP_SIZE - 1);
    localparam logic [SLOT_W:0] POP_V = (SLOT_W+1)'(POP_SIZE);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_WR_I = 6'b000100,
        ST_WR_P = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_i;
    logic [AW-1:0]            r_j;
    logic                     r_issue;
    logic                     r_dv;
    logic [AW-1:0]            r_di;
    t_entry                   r_cur;
    t_entry                   r_best;
    logic [AW-1:0]            r_pick;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_div_go;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    t_entry                   ram_wdata;
    logic                     ram_re;
    t_entry                   ram_q;
    logic                     div_done;
    logic signed [FIT_W-1:0]  div_mean;
    logic signed [FIT_W-1:0]  q_fit;
    logic signed [FIT_W-1:0]  best_fit;
    logic                     load_req;
    logic                     swap;

    assign busy     = (r_state != ST_IDLE);
    assign load_req = start && (r_state == ST_IDLE) && (i_action == ACT_LOAD)
                      && ({1'b0, i_slot} < POP_V);
    assign q_fit    = ram_q.fit;
    assign best_fit = r_best.fit;
    assign swap     = (r_pick != r_i);

    // single write port shared by loads and the two swap writes
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = r_best;
        case (r_state)
            ST_IDLE: begin
                ram_we        = load_req;
                ram_waddr     = i_slot[AW-1:0];
                ram_wdata.fit = i_fitness;
                ram_wdata.tag = i_tag;
            end
            ST_WR_I: begin
                ram_we = swap;
            end
            ST_WR_P: begin
                ram_we    = swap;
                ram_waddr = r_pick;
                ram_wdata = r_cur;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_re = r_issue && ((r_state == ST_SCAN) || (r_state == ST_OUT));

    rsp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (POP_SIZE),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_j),
        .o_rdata (ram_q)
    );

    rsp_div #(
        .DIVISOR (POP_SIZE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_sum   (r_sum),
        .o_done  (div_done),
        .o_mean  (div_mean)
    );

    // divide starts in the cycle after the last swap write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= (r_state == ST_WR_P) && (r_i == LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issue  <= 1'b0;
            r_dv     <= 1'b0;
            r_sum    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (start && (i_action == ACT_SORT)) begin
                        r_sum   <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_issue <= 1'b1;
                        r_dv    <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // stream entries i .. last through the read port
                    if (r_issue) begin
                        r_dv <= 1'b1;
                        r_di <= r_j;
                        if (r_j == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv) begin
                        if (r_di == r_i) begin
                            r_cur  <= ram_q;
                            r_best <= ram_q;
                            r_pick <= r_i;
                        end else if (q_fit > best_fit) begin
                            // strictly greater keeps the first of equal entries
                            r_best <= ram_q;
                            r_pick <= r_di;
                        end
                        if (r_di == LAST_IDX) begin
                            r_state <= ST_WR_I;
                        end
                    end
                end
                ST_WR_I: begin
                    r_sum   <= r_sum + SUM_W'(best_fit);
                    r_state <= ST_WR_P;
                end
                ST_WR_P: begin
                    r_dv <= 1'b0;
                    if (r_i == LAST_IDX) begin
                        r_state  <= ST_DIV;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= r_i + 1'b1;
                        r_issue <= 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_j     <= '0;
                        r_issue <= 1'b1;
                        r_dv    <= 1'b0;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (r_issue) begin
                        r_dv <= 1'b1;
                        r_di <= r_j;
                        if (r_j == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv && (r_di == LAST_IDX)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_issue <= 1'b0;
                    r_dv    <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid          = r_dv && (r_state == ST_OUT);
    assign o_rank           = RANK_W'(r_di);
    assign o_ranked_fitness = ram_q.fit;
    assign o_ranked_tag     = ram_q.tag;
    assign o_last           = o_valid && (r_di == LAST_IDX);
    assign o_mean_fitness   = o_last ? div_mean : '0;

endmodule

`default_nettype wire

>>> hw/rtl/rsp_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module rsp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rsp_div.sv
// signed divide of the fitness sum by the population size, truncating toward zero
`default_nettype none

module rsp_div #(
    parameter int DIVISOR = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [rsp_pkg::SUM_W-1:0] i_sum,
    output logic                                  o_done,
    output logic signed [rsp_pkg::FIT_W-1:0]      o_mean
);
    import rsp_pkg::*;

    // the magnitude of a sum of at most 32 fitnesses fits 37 bits; it is split
    // into a high and a low digit, each divided by a reciprocal multiply
    localparam int MAG_W = 37;
    localparam int LO_W  = 18;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int DL    = $clog2(DIVISOR);
    // remainder of the high digit joined to the low digit
    localparam int XW    = DL + LO_W;
    localparam int KA    = HI_W + DL;
    localparam int KB    = XW + DL;
    localparam int MA_W  = HI_W + 1;
    localparam int MB_W  = XW + 1;
    localparam int PA_W  = HI_W + MA_W;
    localparam int PB_W  = XW + MB_W;
    localparam logic [MA_W-1:0] RCP_A =
        MA_W'(((longint'(1) << KA) + longint'(DIVISOR) - 1) / longint'(DIVISOR));
    localparam logic [MB_W-1:0] RCP_B =
        MB_W'(((longint'(1) << KB) + longint'(DIVISOR) - 1) / longint'(DIVISOR));
    localparam logic [HI_W-1:0] DIV_HI = HI_W'(DIVISOR);

    logic [2:0]        r_stg;
    logic              r_done;
    logic              r_neg;
    logic [HI_W-1:0]   r_hi;
    logic [LO_W-1:0]   r_lo;
    logic [HI_W-1:0]   r_q1;
    logic [XW-1:0]     r_x;
    logic [MAG_W-1:0]  r_q;
    logic [MAG_W-1:0]  mag;
    logic [PA_W-1:0]   prod_a;
    logic [PB_W-1:0]   prod_b;
    logic [DL-1:0]     rem_a;
    logic [MAG_W-1:0]  q_signed;

    assign mag    = MAG_W'(i_sum[SUM_W-1] ? -i_sum : i_sum);
    assign prod_a = {{MA_W{1'b0}}, r_hi} * {{HI_W{1'b0}}, RCP_A};
    assign rem_a  = DL'(r_hi - (r_q1 * DIV_HI));
    assign prod_b = {{MB_W{1'b0}}, r_x} * {{XW{1'b0}}, RCP_B};

    // three stages: high quotient, remainder join, low quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= '0;
            r_done <= 1'b0;
        end else begin
            r_stg  <= {r_stg[1:0], i_start};
            r_done <= r_stg[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi  <= mag[MAG_W-1:LO_W];
            r_lo  <= mag[LO_W-1:0];
            r_neg <= i_sum[SUM_W-1];
        end
        if (r_stg[0]) begin
            r_q1 <= HI_W'(prod_a >> KA);
        end
        if (r_stg[1]) begin
            r_x <= {rem_a, r_lo};
        end
        if (r_stg[2]) begin
            r_q <= {r_q1, LO_W'(prod_b >> KB)};
        end
    end

    // truncation toward zero: divide the magnitude, then restore the sign
    assign q_signed = r_neg ? (~r_q + 1'b1) : r_q;
    assign o_mean   = q_signed[FIT_W-1:0];
    assign o_done   = r_done;

endmodule

`default_nettype wire
